// ----- rtl/nsi_pkg.sv -----
// shared types, constants and micro-sequence table of the simpson integrator
package nsi_pkg;

    localparam int XW        = 32;   // input field width
    localparam int SUM_W     = 64;   // q32.32 result width
    localparam int OUT_FRAC  = 32;   // fraction bits of the result
    localparam int WW        = 160;  // exact intermediate width
    localparam int BW        = 36;   // signed multiplier operand width
    localparam int DIG_W     = 8;    // multiplier digit width
    localparam int DIGITS    = 5;    // digits per multiplier operand
    localparam int MB_W      = DIG_W * DIGITS;
    localparam int DIV_STEPS = SUM_W + 1;
    localparam int Q_W       = DIV_STEPS;
    localparam int K_W       = 4;
    localparam int SIX       = 6;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef logic [WW-1:0] t_wide;

    typedef enum logic [2:0] {
        A_H    = 3'd0,
        A_H1   = 3'd1,
        A_H0   = 3'd2,
        A_PROD = 3'd3,
        A_SUM  = 3'd4,
        A_DW   = 3'd5
    } t_asel;

    typedef enum logic [3:0] {
        B_H   = 4'd0,
        B_F1  = 4'd1,
        B_G0  = 4'd2,
        B_F0  = 4'd3,
        B_G1  = 4'd4,
        B_F2  = 4'd5,
        B_H1  = 4'd6,
        B_SIX = 4'd7,
        B_FS  = 4'd8
    } t_bsel;

    typedef enum logic [2:0] {
        P_NONE  = 3'd0,
        P_S_SET = 3'd1,
        P_S_SUB = 3'd2,
        P_S_ADD = 3'd3,
        P_NUM   = 3'd4,
        P_DEN   = 3'd5,
        P_TRAP  = 3'd6
    } t_post;

    typedef struct packed {
        t_asel a_sel;
        t_bsel b_sel;
        t_post post;
        logic  last;
    } t_mstep;

    typedef struct packed {
        logic  capture;
        logic  prep;
        logic  mul_load;
        logic  mul_step;
        logic  post_en;
        t_post post;
        t_asel a_sel;
        t_bsel b_sel;
        logic  set_error;
        logic  div_load;
        logic  div_step;
        logic  round;
        logic  accum;
        logic  commit;
        logic  commit_clear;
        logic  commit_slot;
        logic  load_out;
    } t_cmd;

    typedef struct packed {
        logic zero_width;
    } t_stat;

    // panel: num = H*(f1*H*H - f0*h1*g0 + f2*h0*g1), den = 6*h0*h1
    // trapezoid: num = dw*fs, den = 2
    function automatic t_mstep mstep(input logic trap, input logic [K_W-1:0] k);
        t_mstep m;
        m = '{a_sel: A_H, b_sel: B_H, post: P_NONE, last: 1'b1};
        if (trap) begin
            m = '{a_sel: A_DW, b_sel: B_FS, post: P_TRAP, last: 1'b1};
        end else begin
            case (k)
                4'd0: m = '{a_sel: A_H,    b_sel: B_H,   post: P_NONE,  last: 1'b0};
                4'd1: m = '{a_sel: A_PROD, b_sel: B_F1,  post: P_S_SET, last: 1'b0};
                4'd2: m = '{a_sel: A_H1,   b_sel: B_G0,  post: P_NONE,  last: 1'b0};
                4'd3: m = '{a_sel: A_PROD, b_sel: B_F0,  post: P_S_SUB, last: 1'b0};
                4'd4: m = '{a_sel: A_H0,   b_sel: B_G1,  post: P_NONE,  last: 1'b0};
                4'd5: m = '{a_sel: A_PROD, b_sel: B_F2,  post: P_S_ADD, last: 1'b0};
                4'd6: m = '{a_sel: A_SUM,  b_sel: B_H,   post: P_NUM,   last: 1'b0};
                4'd7: m = '{a_sel: A_H0,   b_sel: B_H1,  post: P_NONE,  last: 1'b0};
                4'd8: m = '{a_sel: A_PROD, b_sel: B_SIX, post: P_DEN,   last: 1'b1};
                default: m = '{a_sel: A_H, b_sel: B_H, post: P_NONE, last: 1'b1};
            endcase
        end
        return m;
    endfunction

endpackage

// ----- rtl/nsi_if.sv -----
// point and result channel interfaces
interface nsi_point_if;
    logic                             valid;
    logic                             ready;
    logic signed [nsi_pkg::XW-1:0]    point_x;
    logic signed [nsi_pkg::XW-1:0]    point_value;
    logic                             last_point;

    modport source(output valid, point_x, point_value, last_point, input ready);
    modport sink(input valid, point_x, point_value, last_point, output ready);
endinterface

interface nsi_result_if;
    logic                             valid;
    logic                             ready;
    logic signed [nsi_pkg::SUM_W-1:0] integral;
    logic                             div_error;
    logic                             saturated;

    modport source(output valid, integral, div_error, saturated, input ready);
    modport sink(input valid, integral, div_error, saturated, output ready);
endinterface

// ----- rtl/nsi_datapath.sv -----
// datapath: held points, serial multiplier, restoring divider, saturating sum
module nsi_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  nsi_pkg::t_cmd                    i_cmd,
    input  logic signed [nsi_pkg::XW-1:0]    i_point_x,
    input  logic signed [nsi_pkg::XW-1:0]    i_point_value,
    output nsi_pkg::t_stat                   o_stat,
    output logic signed [nsi_pkg::SUM_W-1:0] o_integral,
    output logic                             o_div_error,
    output logic                             o_saturated
);

    localparam int NUM_SHL = (2 * FRAC_BITS < nsi_pkg::OUT_FRAC) ?
                             nsi_pkg::OUT_FRAC - 2 * FRAC_BITS : 0;
    localparam int DEN_SHL = (2 * FRAC_BITS > nsi_pkg::OUT_FRAC) ?
                             2 * FRAC_BITS - nsi_pkg::OUT_FRAC : 0;
    localparam int WW = nsi_pkg::WW;
    localparam int BW = nsi_pkg::BW;
    localparam int SW = nsi_pkg::SUM_W;

    logic signed [nsi_pkg::XW-1:0] r_hx [2];
    logic signed [nsi_pkg::XW-1:0] r_hv [2];
    logic signed [nsi_pkg::XW-1:0] r_in_x;
    logic signed [nsi_pkg::XW-1:0] r_in_f;
    logic signed [32:0]            r_h0, r_h1, r_dw, r_fs;
    logic signed [33:0]            r_hh;
    logic signed [34:0]            r_g0, r_g1;
    logic                          r_zero;

    nsi_pkg::t_wide             r_ma, r_prod, r_s, r_num, r_den, r_rem, r_dd;
    logic [nsi_pkg::MB_W-1:0]   r_mb;
    logic                       r_neg;
    logic [nsi_pkg::Q_W-1:0]    r_q;
    logic [SW-1:0]              r_term;
    logic                       r_tclip;
    logic [SW-1:0]              r_sum;
    logic                       r_err, r_clip;
    logic [SW-1:0]              r_o_int;
    logic                       r_o_err, r_o_sat;

    // prep arithmetic
    logic signed [32:0] h0, h1, dw, fs;
    logic signed [33:0] hh;
    logic signed [34:0] g0, g1;

    always_comb begin
        h0 = 33'(r_hx[1]) - 33'(r_hx[0]);
        h1 = 33'(r_in_x) - 33'(r_hx[1]);
        hh = 34'(h0) + 34'(h1);
        g0 = 35'(h1) - (35'(h0) <<< 1);
        g1 = (35'(h1) <<< 1) - 35'(h0);
        dw = 33'(r_in_x) - 33'(r_hx[0]);
        fs = 33'(r_hv[0]) + 33'(r_in_f);
    end

    // multiplier operand select
    nsi_pkg::t_wide         a_ext, a_load, pp;
    logic signed [BW-1:0]   b_val;
    logic [BW-1:0]          b_mag;
    logic                   b_neg;

    always_comb begin
        case (i_cmd.a_sel)
            nsi_pkg::A_H:    a_ext = WW'(r_hh);
            nsi_pkg::A_H1:   a_ext = WW'(r_h1);
            nsi_pkg::A_H0:   a_ext = WW'(r_h0);
            nsi_pkg::A_PROD: a_ext = r_prod;
            nsi_pkg::A_SUM:  a_ext = r_s;
            nsi_pkg::A_DW:   a_ext = WW'(r_dw);
            default:         a_ext = '0;
        endcase
        case (i_cmd.b_sel)
            nsi_pkg::B_H:   b_val = BW'(r_hh);
            nsi_pkg::B_F1:  b_val = BW'(r_hv[1]);
            nsi_pkg::B_G0:  b_val = BW'(r_g0);
            nsi_pkg::B_F0:  b_val = BW'(r_hv[0]);
            nsi_pkg::B_G1:  b_val = BW'(r_g1);
            nsi_pkg::B_F2:  b_val = BW'(r_in_f);
            nsi_pkg::B_H1:  b_val = BW'(r_h1);
            nsi_pkg::B_SIX: b_val = BW'(nsi_pkg::SIX);
            nsi_pkg::B_FS:  b_val = BW'(r_fs);
            default:        b_val = '0;
        endcase
        b_neg  = b_val[BW-1];
        b_mag  = b_neg ? BW'(-b_val) : BW'(b_val);
        // fold the multiplier sign into the wide operand
        a_load = b_neg ? -a_ext : a_ext;
        pp     = r_ma * {{(WW-nsi_pkg::DIG_W){1'b0}}, r_mb[nsi_pkg::DIG_W-1:0]};
    end

    // divider
    nsi_pkg::t_wide num_mag, den_mag, d_nx;
    logic           div_ge, rnd;
    logic [nsi_pkg::Q_W:0] qr;
    logic [SW-1:0]  mag, term_nx;
    logic           tclip_nx;

    always_comb begin
        num_mag = r_num[WW-1] ? -r_num : r_num;
        den_mag = r_den[WW-1] ? -r_den : r_den;
        d_nx    = r_dd >> 1;
        div_ge  = (r_rem >= d_nx);
        rnd     = ({r_rem, 1'b0} >= {1'b0, r_dd});
        qr      = {1'b0, r_q} + (nsi_pkg::Q_W + 1)'(rnd);
        mag     = qr[SW-1:0];
        tclip_nx = 1'b0;
        if (qr[nsi_pkg::Q_W:SW] != '0) begin
            tclip_nx = 1'b1;
            term_nx  = r_neg ? nsi_pkg::SUM_MIN : nsi_pkg::SUM_MAX;
        end else if (r_neg) begin
            if (mag > nsi_pkg::SUM_MIN) begin
                tclip_nx = 1'b1;
                term_nx  = nsi_pkg::SUM_MIN;
            end else begin
                term_nx = -mag;
            end
        end else if (mag[SW-1]) begin
            tclip_nx = 1'b1;
            term_nx  = nsi_pkg::SUM_MAX;
        end else begin
            term_nx = mag;
        end
    end

    // saturating accumulate
    logic [SW:0]   s65;
    logic          s_ovf;
    logic [SW-1:0] sum_nx;

    always_comb begin
        s65    = {r_sum[SW-1], r_sum} + {r_term[SW-1], r_term};
        s_ovf  = s65[SW] ^ s65[SW-1];
        sum_nx = s_ovf ? (s65[SW] ? nsi_pkg::SUM_MIN : nsi_pkg::SUM_MAX) : s65[SW-1:0];
    end

    // control-bearing state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_err   <= 1'b0;
            r_clip  <= 1'b0;
            r_hx[0] <= '0;
            r_hx[1] <= '0;
            r_hv[0] <= '0;
            r_hv[1] <= '0;
        end else begin
            if (i_cmd.set_error) begin
                r_err <= 1'b1;
            end
            if (i_cmd.accum) begin
                r_sum  <= sum_nx;
                r_clip <= r_clip | s_ovf | r_tclip;
            end
            if (i_cmd.commit) begin
                if (i_cmd.commit_clear) begin
                    r_sum  <= '0;
                    r_err  <= 1'b0;
                    r_clip <= 1'b0;
                end
                r_hx[i_cmd.commit_slot] <= r_in_x;
                r_hv[i_cmd.commit_slot] <= r_in_f;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_x <= i_point_x;
            r_in_f <= i_point_value;
        end
        if (i_cmd.prep) begin
            r_h0   <= h0;
            r_h1   <= h1;
            r_hh   <= hh;
            r_g0   <= g0;
            r_g1   <= g1;
            r_dw   <= dw;
            r_fs   <= fs;
            r_zero <= (h0 == '0) || (h1 == '0);
        end
        if (i_cmd.mul_load) begin
            r_ma   <= a_load;
            r_mb   <= nsi_pkg::MB_W'(b_mag);
            r_prod <= '0;
        end
        if (i_cmd.mul_step) begin
            r_prod <= r_prod + pp;
            r_ma   <= r_ma << nsi_pkg::DIG_W;
            r_mb   <= r_mb >> nsi_pkg::DIG_W;
        end
        if (i_cmd.post_en) begin
            case (i_cmd.post)
                nsi_pkg::P_S_SET: r_s <= r_prod;
                nsi_pkg::P_S_SUB: r_s <= r_s - r_prod;
                nsi_pkg::P_S_ADD: r_s <= r_s + r_prod;
                nsi_pkg::P_NUM:   r_num <= r_prod;
                nsi_pkg::P_DEN:   r_den <= r_prod;
                nsi_pkg::P_TRAP: begin
                    r_num <= r_prod;
                    r_den <= WW'(2);
                end
                default: ;
            endcase
        end
        if (i_cmd.div_load) begin
            r_neg <= r_num[WW-1] ^ r_den[WW-1];
            r_rem <= num_mag << NUM_SHL;
            r_dd  <= (den_mag << DEN_SHL) << nsi_pkg::DIV_STEPS;
            r_q   <= '0;
        end
        if (i_cmd.div_step) begin
            r_dd  <= d_nx;
            r_rem <= div_ge ? r_rem - d_nx : r_rem;
            r_q   <= {r_q[nsi_pkg::Q_W-2:0], div_ge};
        end
        if (i_cmd.round) begin
            r_term  <= term_nx;
            r_tclip <= tclip_nx;
        end
        if (i_cmd.load_out) begin
            r_o_int <= r_sum;
            r_o_err <= r_err;
            r_o_sat <= r_clip;
        end
    end

    assign o_stat.zero_width = r_zero;
    assign o_integral        = r_o_int;
    assign o_div_error       = r_o_err;
    assign o_saturated       = r_o_sat;

endmodule

// ----- rtl/nsi_ctrl.sv -----
// controller: point phase, multiply/divide sequencing, result handoff
module nsi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_last,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  nsi_pkg::t_stat i_st,
    output nsi_pkg::t_cmd  o_cmd
);

    localparam int DIG_CW = $clog2(nsi_pkg::DIGITS);
    localparam int DCNT_W = $clog2(nsi_pkg::DIV_STEPS);

    localparam logic [1:0] PH_NONE  = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_MID   = 2'd2;
    localparam logic [1:0] PH_BAD   = 2'd3;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_PREP   = 11'b00000000010,
        S_MLOAD  = 11'b00000000100,
        S_MSTEP  = 11'b00000001000,
        S_MPOST  = 11'b00000010000,
        S_DLOAD  = 11'b00000100000,
        S_DSTEP  = 11'b00001000000,
        S_ROUND  = 11'b00010000000,
        S_ACCUM  = 11'b00100000000,
        S_COMMIT = 11'b01000000000,
        S_RESULT = 11'b10000000000
    } t_state;

    t_state                  r_state, n_state;
    logic [1:0]              r_phase, n_phase;
    logic                    r_last, n_last;
    logic                    r_trap, n_trap;
    logic [nsi_pkg::K_W-1:0] r_k, n_k;
    logic [DIG_CW-1:0]       r_dig, n_dig;
    logic [DCNT_W-1:0]       r_dcnt, n_dcnt;
    logic                    r_out_valid, n_out_valid;
    nsi_pkg::t_mstep         ms;
    nsi_pkg::t_cmd           cmd;

    always_comb begin
        ms          = nsi_pkg::mstep(r_trap, r_k);
        n_state     = r_state;
        n_phase     = r_phase;
        n_last      = r_last;
        n_trap      = r_trap;
        n_k         = r_k;
        n_dig       = r_dig;
        n_dcnt      = r_dcnt;
        cmd         = '0;
        cmd.a_sel   = ms.a_sel;
        cmd.b_sel   = ms.b_sel;
        cmd.post    = ms.post;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_last      = i_last;
                    n_state     = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep = 1'b1;
                n_k      = '0;
                n_trap   = (r_phase == PH_START) && r_last;
                if ((r_phase == PH_MID) || ((r_phase == PH_START) && r_last)) begin
                    n_state = S_MLOAD;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_MLOAD: begin
                // degenerate panel adds nothing and only flags the error
                if (!r_trap && (r_k == '0) && i_st.zero_width) begin
                    cmd.set_error = 1'b1;
                    n_state       = S_COMMIT;
                end else begin
                    cmd.mul_load = 1'b1;
                    n_dig        = '0;
                    n_state      = S_MSTEP;
                end
            end
            S_MSTEP: begin
                cmd.mul_step = 1'b1;
                if (r_dig == DIG_CW'(nsi_pkg::DIGITS - 1)) begin
                    n_state = S_MPOST;
                end else begin
                    n_dig = r_dig + DIG_CW'(1);
                end
            end
            S_MPOST: begin
                cmd.post_en = 1'b1;
                if (ms.last) begin
                    n_state = S_DLOAD;
                end else begin
                    n_k     = r_k + nsi_pkg::K_W'(1);
                    n_state = S_MLOAD;
                end
            end
            S_DLOAD: begin
                cmd.div_load = 1'b1;
                n_dcnt       = '0;
                n_state      = S_DSTEP;
            end
            S_DSTEP: begin
                cmd.div_step = 1'b1;
                if (r_dcnt == DCNT_W'(nsi_pkg::DIV_STEPS - 1)) begin
                    n_state = S_ROUND;
                end else begin
                    n_dcnt = r_dcnt + DCNT_W'(1);
                end
            end
            S_ROUND: begin
                cmd.round = 1'b1;
                n_state   = S_ACCUM;
            end
            S_ACCUM: begin
                cmd.accum = 1'b1;
                n_state   = S_COMMIT;
            end
            S_COMMIT: begin
                cmd.commit       = 1'b1;
                cmd.commit_clear = (r_phase != PH_START) && (r_phase != PH_MID);
                cmd.commit_slot  = (r_phase == PH_START);
                n_phase          = (r_phase == PH_START) ? PH_MID : PH_START;
                if (r_last) begin
                    n_phase = PH_NONE;
                    n_state = S_RESULT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = r_out_valid && !i_out_ready;
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_NONE;
            r_last      <= 1'b0;
            r_trap      <= 1'b0;
            r_k         <= '0;
            r_dig       <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_last      <= n_last;
            r_trap      <= n_trap;
            r_k         <= n_k;
            r_dig       <= n_dig;
            r_dcnt      <= n_dcnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_PREP))
        else $error("accepted point not followed by prep");

    a_result_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> r_last)
        else $error("result loaded for a point without last flag");

    a_result_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (r_phase == PH_NONE))
        else $error("phase not cleared at result");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DSTEP) |-> (r_dcnt <= DCNT_W'(nsi_pkg::DIV_STEPS - 1)))
        else $error("divider step count out of range");

    a_phase_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_BAD)
        else $error("illegal panel phase");

endmodule

// ----- rtl/nonuniform_simpson_integrator.sv -----
// top level: non-uniform composite simpson integrator over a point stream
// sequence: a point that closes a panel runs prep, 9 serial multiplies, divider load,
//   65 divider steps, round, accumulate and commit; a last point after an odd run
//   runs its trapezoid the same way with a single multiply; any other point runs prep
//   and commit only; a last point then adds the result handoff, which is held while the
//   earlier result still waits for transfer
// throughput: one point at a time; the radix-256 serial multiplier and the
//   one-bit-per-cycle divider set the busy time of a point
// reset: synchronous active low; clears phase, held points, sum and flags
module nonuniform_simpson_integrator #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nsi_point_if.sink     i_point,
    nsi_result_if.source  o_result
);

    // command and status between sequencer and datapath
    nsi_pkg::t_cmd  cmd;
    nsi_pkg::t_stat st;

    // controller owns the handshakes; the result payload sits in the datapath
    // output register, so the next point is taken while a result waits for transfer
    nsi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_point.valid),
        .i_last      (i_point.last_point),
        .o_in_ready  (i_point.ready),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    // exact 160-bit arithmetic, scaled to q32.32, rounded half away from zero
    nsi_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_point_x     (i_point.point_x),
        .i_point_value (i_point.point_value),
        .o_stat        (st),
        .o_integral    (o_result.integral),
        .o_div_error   (o_result.div_error),
        .o_saturated   (o_result.saturated)
    );

endmodule
